### rtl/sdd_pkg.sv
// Shared types and constants for the sector disk DMA controller.
package sdd_pkg;

  // Words in one sector, and the width of a word offset inside it.
  localparam int SECTOR_WORDS = 128;
  localparam int WORD_W       = $clog2(SECTOR_WORDS);

  // Status register values and mask.
  localparam logic [3:0] STATUS_DONE  = 4'h4;
  localparam logic [3:0] STATUS_ERROR = 4'hc;
  localparam logic [3:0] STATUS_MASK  = 4'hf;

  // Register offsets from the base address, and the DMA step in bytes.
  localparam logic [31:0] OFS_POINTER = 32'd0;
  localparam logic [31:0] OFS_SECTOR  = 32'd4;
  localparam logic [31:0] OFS_STATUS  = 32'd8;
  localparam logic [31:0] WORD_BYTES  = 32'd4;

  // Interrupt line number that drives nothing.
  localparam logic [2:0] IRQ_NONE = 3'd7;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BASE    = 2'd0,
    CFG_COUNT   = 2'd1,
    CFG_IRQ     = 2'd2,
    CFG_PRESENT = 2'd3
  } cfg_index_t;

  // Input beat opcodes.
  typedef enum logic [1:0] {
    OP_BUS_RD = 2'd0,
    OP_BUS_WR = 2'd1,
    OP_TICK   = 2'd2,
    OP_RESP   = 2'd3
  } opcode_t;

  // Classified work handed from the front to the back.
  typedef enum logic [3:0] {
    KIND_NOP,
    KIND_RD_PTR,
    KIND_RD_SECT,
    KIND_RD_STAT,
    KIND_WR_PTR,
    KIND_WR_SECT,
    KIND_WR_STAT,
    KIND_TICK,
    KIND_RESP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] data;
  } work_t;

  // Configuration as seen by the front and the back.
  typedef struct packed {
    logic [31:0] base_address;
    logic [6:0]  sector_count;
    logic [2:0]  irq_number;
    logic        image_present;
  } disk_cfg_t;

endpackage

### rtl/sdd_front.sv
// Front end: accepts input beats and classifies them into work items.
module sdd_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_tuser,
  input  logic [63:0]       in_tdata,
  input  sdd_pkg::disk_cfg_t cfg,
  input  logic              q_ready,
  input  logic              clr_busy,
  output logic              q_push,
  output sdd_pkg::work_t    q_entry
);
  import sdd_pkg::*;

  logic [31:0] bus_addr;
  logic        hit_ptr;
  logic        hit_sect;
  logic        hit_stat;

  assign bus_addr = in_tdata[31:0];

  // Register decode; the offsets wrap at 32 bits like the bus does.
  assign hit_ptr  = (bus_addr == cfg.base_address + OFS_POINTER);
  assign hit_sect = (bus_addr == cfg.base_address + OFS_SECTOR);
  assign hit_stat = (bus_addr == cfg.base_address + OFS_STATUS);

  // Nothing is taken while the image store is being cleared.
  assign in_tready = q_ready & ~clr_busy;
  assign q_push    = in_tvalid & in_tready;

  // Classify the beat; bus accesses miss when no image is attached.
  always_comb begin
    q_entry.data = in_tdata[63:32];
    q_entry.kind = KIND_NOP;
    case (opcode_t'(in_tuser))
      OP_BUS_RD: begin
        if (cfg.image_present) begin
          if (hit_ptr) begin
            q_entry.kind = KIND_RD_PTR;
          end else if (hit_sect) begin
            q_entry.kind = KIND_RD_SECT;
          end else if (hit_stat) begin
            q_entry.kind = KIND_RD_STAT;
          end
        end
      end
      OP_BUS_WR: begin
        if (cfg.image_present) begin
          if (hit_ptr) begin
            q_entry.kind = KIND_WR_PTR;
          end else if (hit_sect) begin
            q_entry.kind = KIND_WR_SECT;
          end else if (hit_stat) begin
            q_entry.kind = KIND_WR_STAT;
          end
        end
      end
      OP_TICK: q_entry.kind = KIND_TICK;
      OP_RESP: q_entry.kind = KIND_RESP;
      default: q_entry.kind = KIND_NOP;
    endcase
  end

endmodule

### rtl/sdd_queue.sv
// Two-entry queue of work items between the front and the back.
module sdd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sdd_pkg::work_t push_entry,
  output logic           ready,
  input  logic           pop,
  output logic           valid,
  output sdd_pkg::work_t head
);
  import sdd_pkg::*;

  work_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign ready = (count_r != 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = slot_r[rd_ptr_r];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/sdd_back.sv
// Back end: register state, DMA sequencing, image store and result register.
module sdd_back #(
  parameter int MAX_SECTORS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sdd_pkg::disk_cfg_t cfg,
  input  logic               q_valid,
  input  sdd_pkg::work_t     q_head,
  output logic               q_pop,
  output logic               clr_busy,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [111:0]       out_tdata
);
  import sdd_pkg::*;

  localparam int SECT_W    = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int IMG_DEPTH = MAX_SECTORS * SECTOR_WORDS;
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam logic [IMG_AW-1:0] IMG_LAST  = IMG_AW'(IMG_DEPTH - 1);
  localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(SECTOR_WORDS - 1);
  localparam logic [31:0]       MAX_SECT  = 32'(MAX_SECTORS);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_TO_MEM  = 2'd1,
    MODE_TO_DISK = 2'd2
  } mode_t;

  // Device state.
  logic [31:0]       ptr_r, ptr_nxt;
  logic [31:0]       sect_r, sect_nxt;
  logic [3:0]        stat_r, stat_nxt;
  mode_t             mode_r, mode_nxt;
  logic [WORD_W-1:0] wc_r, wc_nxt;
  logic [SECT_W-1:0] act_r, act_nxt;
  logic              irq_r, irq_nxt;
  logic              rdo_r, rdo_nxt;

  // Clearing pass over the image store.
  logic              clr_busy_r;
  logic [IMG_AW-1:0] clr_addr_r;

  // Result register.
  logic              out_valid_r;
  logic              res_hit_r;
  logic [31:0]       res_rdata_r;
  logic              res_mw_r;
  logic              res_mr_r;
  logic [31:0]       res_maddr_r;
  logic [6:0]        res_irq_r;

  // Result of the item being executed.
  logic              hit;
  logic [31:0]       rdata;
  logic              mw;
  logic              mr;
  logic [31:0]       maddr;
  logic [6:0]        irq_vec;

  // Image store.
  logic [31:0]       img_mem [IMG_DEPTH];
  logic [31:0]       img_rdata_r;
  logic [IMG_AW-1:0] img_addr;
  logic              img_we;
  logic [IMG_AW-1:0] img_waddr;
  logic [31:0]       img_wdata;
  logic              img_re;
  logic              resp_store;

  logic              exec;
  logic              count_word;
  logic [1:0]        cmd;
  logic [31:0]       limit;

  assign clr_busy = clr_busy_r;
  assign exec     = q_valid & (~out_valid_r | out_tready) & ~clr_busy_r;
  assign q_pop    = exec;
  assign img_addr = IMG_AW'({act_r, wc_r});
  assign cmd      = q_head.data[1:0];

  // Sectors beyond the store's size do not exist, whatever the count says.
  assign limit = (32'(cfg.sector_count) > MAX_SECT) ? MAX_SECT : 32'(cfg.sector_count);

  // Execute one work item against the device state.
  always_comb begin
    ptr_nxt    = ptr_r;
    sect_nxt   = sect_r;
    stat_nxt   = stat_r;
    mode_nxt   = mode_r;
    wc_nxt     = wc_r;
    act_nxt    = act_r;
    irq_nxt    = irq_r;
    rdo_nxt    = rdo_r;
    hit        = 1'b0;
    rdata      = '0;
    mw         = 1'b0;
    mr         = 1'b0;
    maddr      = '0;
    count_word = 1'b0;
    img_re     = 1'b0;
    resp_store = 1'b0;
    case (q_head.kind)
      KIND_RD_PTR: begin
        hit   = 1'b1;
        rdata = ptr_r;
      end
      KIND_RD_SECT: begin
        hit   = 1'b1;
        rdata = sect_r;
      end
      KIND_RD_STAT: begin
        hit   = 1'b1;
        rdata = 32'(stat_r);
      end
      KIND_WR_PTR:  ptr_nxt  = q_head.data;
      KIND_WR_SECT: sect_nxt = q_head.data;
      KIND_WR_STAT: begin
        // A pending completion or error interrupt (status bit 2 set) is acknowledged by the write.
        if (stat_r[2]) begin
          irq_nxt = 1'b0;
        end
        stat_nxt = q_head.data[3:0] & STATUS_MASK;
        if ((cmd == 2'(MODE_TO_MEM) || cmd == 2'(MODE_TO_DISK)) && mode_r == MODE_IDLE) begin
          if (sect_r >= limit) begin
            stat_nxt = STATUS_ERROR;
            irq_nxt  = 1'b1;
          end else begin
            mode_nxt = mode_t'(cmd);
            wc_nxt   = '0;
            act_nxt  = sect_r[SECT_W-1:0];
            rdo_nxt  = 1'b0;
          end
        end
      end
      KIND_TICK: begin
        if (mode_r == MODE_TO_MEM) begin
          mw         = 1'b1;
          maddr      = ptr_r;
          ptr_nxt    = ptr_r + WORD_BYTES;
          img_re     = 1'b1;
          count_word = 1'b1;
        end else if (mode_r == MODE_TO_DISK && !rdo_r) begin
          mr      = 1'b1;
          maddr   = ptr_r;
          ptr_nxt = ptr_r + WORD_BYTES;
          rdo_nxt = 1'b1;
        end
      end
      KIND_RESP: begin
        // Responses that match no outstanding request are dropped.
        if (mode_r == MODE_TO_DISK && rdo_r) begin
          resp_store = 1'b1;
          rdo_nxt    = 1'b0;
          count_word = 1'b1;
        end
      end
      default: ;
    endcase
    // The last word of a sector ends the transfer.
    if (count_word) begin
      if (wc_r == WORD_LAST) begin
        wc_nxt   = '0;
        mode_nxt = MODE_IDLE;
        stat_nxt = STATUS_DONE;
        irq_nxt  = 1'b1;
      end else begin
        wc_nxt = wc_r + 1'b1;
      end
    end
    irq_vec = (irq_nxt && cfg.irq_number != IRQ_NONE) ? (7'b1 << cfg.irq_number) : 7'd0;
  end

  // Image store write port: the clearing pass or a memory response.
  always_comb begin
    img_we    = clr_busy_r | (exec & resp_store);
    img_waddr = clr_busy_r ? clr_addr_r : img_addr;
    img_wdata = clr_busy_r ? '0 : q_head.data;
  end

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_waddr] <= img_wdata;
    end
    if (exec && img_re) begin
      img_rdata_r <= img_mem[img_addr];
    end
  end

  // Device state, the clearing pass and the result register; the result holds
  // while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      sect_r      <= '0;
      stat_r      <= '0;
      mode_r      <= MODE_IDLE;
      wc_r        <= '0;
      act_r       <= '0;
      irq_r       <= 1'b0;
      rdo_r       <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      res_hit_r   <= 1'b0;
      res_rdata_r <= '0;
      res_mw_r    <= 1'b0;
      res_mr_r    <= 1'b0;
      res_maddr_r <= '0;
      res_irq_r   <= '0;
    end else begin
      if (exec) begin
        ptr_r       <= ptr_nxt;
        sect_r      <= sect_nxt;
        stat_r      <= stat_nxt;
        mode_r      <= mode_nxt;
        wc_r        <= wc_nxt;
        act_r       <= act_nxt;
        irq_r       <= irq_nxt;
        rdo_r       <= rdo_nxt;
        res_hit_r   <= hit;
        res_rdata_r <= rdata;
        res_mw_r    <= mw;
        res_mr_r    <= mr;
        res_maddr_r <= maddr;
        res_irq_r   <= irq_vec;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == IMG_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_irq_r, (res_mw_r ? img_rdata_r : 32'd0), res_maddr_r,
                       res_mr_r, res_mw_r, res_rdata_r, res_hit_r};

endmodule

### rtl/sector_disk_dma_controller_top.sv
// Top level of the sector disk DMA controller: configuration registers and datapath.
//
// A disk of MAX_SECTORS sectors of 128 words each, with three bus registers (DMA pointer,
// sector number, status/command) at base_address. Every input beat gives exactly one
// result beat. The block takes one beat per clock cycle when the result side keeps up;
// a result passes through the work queue and then the execute stage, whose results
// and image-store read are registered. After reset a clearing pass zeroes the image
// store one word a cycle, MAX_SECTORS * 128 words (8192 at the default size), during
// which in_tready stays low; configuration writes are taken throughout. Configuration
// should only change while the block is idle.
module sector_disk_dma_controller_top #(
  parameter int MAX_SECTORS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input beats.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // opcode
  input  logic [63:0]  in_tdata,   // bus_address, data_word
  // Result beats.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // read_hit, read_data, mem_write_valid, mem_read_valid,
                                   // mem_address, mem_write_data, irq_lines, zero padding
  // Configuration writes.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import sdd_pkg::*;

  disk_cfg_t cfg_r;
  logic      q_push;
  work_t     q_entry;
  logic      q_ready;
  logic      q_pop;
  logic      q_valid;
  work_t     q_head;
  logic      clr_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address  <= '0;
      cfg_r.sector_count  <= 7'd64;
      cfg_r.irq_number    <= '0;
      cfg_r.image_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_BASE:    cfg_r.base_address  <= cfg_wdata;
        CFG_COUNT:   cfg_r.sector_count  <= cfg_wdata[6:0];
        CFG_IRQ:     cfg_r.irq_number    <= cfg_wdata[2:0];
        CFG_PRESENT: cfg_r.image_present <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  sdd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .q_ready   (q_ready),
    .clr_busy  (clr_busy),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  sdd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  sdd_back #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clr_busy   (clr_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
